### hw/rtl/line_point_generator_unit_defines.svh
// Assertion helpers shared by the line point generator
`ifndef LINE_POINT_GENERATOR_UNIT_DEFINES_SVH
`define LINE_POINT_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define LPG_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("line point generator check failed");

// Next-cycle implication, disabled while in reset
`define LPG_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("line point generator check failed");

`endif

### hw/rtl/lpg_pkg.sv
`default_nettype none

package lpg_pkg;

   // default coordinate width and fixed color width
   localparam int COORD_BITS_DEF = 10;
   localparam int COLOR_BITS     = 16;

   // request operation codes
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // two's complement axis direction codes
   localparam logic [1:0] STEP_ZERO  = 2'b00;
   localparam logic [1:0] STEP_PLUS  = 2'b01;
   localparam logic [1:0] STEP_MINUS = 2'b11;

   // control and status from the line core
   typedef struct packed {
      logic advance;  // request in the input register is consumed
      logic emit;     // a point is written to the result register
      logic last;     // the emitted point ends the line
      logic active;   // a line is being drawn
   } lpg_ctl_type;

endpackage

`default_nettype wire

### hw/rtl/lpg_if.sv
`default_nettype none

// request channel: start or step
interface lpg_req_if #(parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF) ();
   logic                  valid;
   logic                  ready;
   logic                  operation;
   logic [COORD_BITS-1:0] x_start;
   logic [COORD_BITS-1:0] y_start;
   logic [COORD_BITS-1:0] x_end;
   logic [COORD_BITS-1:0] y_end;

   modport source (output valid, operation, x_start, y_start, x_end, y_end, input ready);
   modport sink   (input valid, operation, x_start, y_start, x_end, y_end, output ready);
endinterface

// result channel: one point
interface lpg_rsp_if #(parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF) ();
   logic                           valid;
   logic                           ready;
   logic [COORD_BITS-1:0]          point_x;
   logic [COORD_BITS-1:0]          point_y;
   logic [lpg_pkg::COLOR_BITS-1:0] pixel_color;
   logic                           last_point;

   modport source (output valid, point_x, point_y, pixel_color, last_point, input ready);
   modport sink   (input valid, point_x, point_y, pixel_color, last_point, output ready);
endinterface

// configuration write channel: draw color
interface lpg_csr_if ();
   logic                           valid;
   logic                           ready;
   logic [lpg_pkg::COLOR_BITS-1:0] draw_color;

   modport source (output valid, draw_color, input ready);
   modport sink   (input valid, draw_color, output ready);
endinterface

`default_nettype wire

### hw/rtl/lpg_req_stage.sv
`default_nettype none

module lpg_req_stage #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   lpg_req_if.sink                    req_chan,
   input  wire logic                  advance,
   output logic                       in_valid,
   output logic                       in_operation,
   output logic [COORD_BITS-1:0]      in_x_start,
   output logic [COORD_BITS-1:0]      in_y_start,
   output logic [COORD_BITS-1:0]      in_x_end,
   output logic [COORD_BITS-1:0]      in_y_end
);
   import lpg_pkg::*;

   logic                  valid_ff, valid_in;
   logic                  operation_ff;
   logic [COORD_BITS-1:0] x_start_ff, y_start_ff, x_end_ff, y_end_ff;
   logic                  take;

   // room whenever empty or the held request leaves this cycle
   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // request payload, no reset needed
   always_ff @(posedge clock) begin
      if (take) begin
         operation_ff <= req_chan.operation;
         x_start_ff   <= req_chan.x_start;
         y_start_ff   <= req_chan.y_start;
         x_end_ff     <= req_chan.x_end;
         y_end_ff     <= req_chan.y_end;
      end
   end

   assign in_valid     = valid_ff;
   assign in_operation = operation_ff;
   assign in_x_start   = x_start_ff;
   assign in_y_start   = y_start_ff;
   assign in_x_end     = x_end_ff;
   assign in_y_end     = y_end_ff;

endmodule

`default_nettype wire

### hw/rtl/lpg_line_core.sv
`default_nettype none

module lpg_line_core #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic                  in_operation,
   input  wire logic [COORD_BITS-1:0] in_x_start,
   input  wire logic [COORD_BITS-1:0] in_y_start,
   input  wire logic [COORD_BITS-1:0] in_x_end,
   input  wire logic [COORD_BITS-1:0] in_y_end,
   input  wire logic                  out_free,
   output lpg_pkg::lpg_ctl_type       ctl,
   output logic [COORD_BITS-1:0]      point_x,
   output logic [COORD_BITS-1:0]      point_y
);
   import lpg_pkg::*;

   localparam int ERR_BITS = COORD_BITS + 1;

   logic                  line_active_ff, line_active_in;
   logic [COORD_BITS-1:0] cur_col_ff, cur_col_in;
   logic [COORD_BITS-1:0] cur_row_ff, cur_row_in;
   logic [ERR_BITS-1:0]   col_error_ff, col_error_in;
   logic [ERR_BITS-1:0]   row_error_ff, row_error_in;
   logic [COORD_BITS-1:0] col_delta_ff, col_delta_in;
   logic [COORD_BITS-1:0] row_delta_ff, row_delta_in;
   logic [1:0]            col_step_ff, col_step_in;
   logic [1:0]            row_step_ff, row_step_in;
   logic [COORD_BITS-1:0] major_length_ff, major_length_in;
   logic [ERR_BITS-1:0]   points_left_ff, points_left_in;

   logic [COORD_BITS-1:0] set_col_delta, set_row_delta, set_major;
   logic [1:0]            set_col_step, set_row_step;
   logic [ERR_BITS-1:0]   col_sum, row_sum, major_ext, points_dec;
   logic                  col_hit, row_hit;
   logic [COORD_BITS-1:0] col_moved, row_moved, col_next, row_next;
   logic                  emits, advance, step_last;

   // line setup: absolute deltas, directions, major length
   always_comb begin
      if (in_x_end > in_x_start) begin
         set_col_delta = in_x_end - in_x_start;
         set_col_step  = STEP_PLUS;
      end else if (in_x_end < in_x_start) begin
         set_col_delta = in_x_start - in_x_end;
         set_col_step  = STEP_MINUS;
      end else begin
         set_col_delta = '0;
         set_col_step  = STEP_ZERO;
      end
      if (in_y_end > in_y_start) begin
         set_row_delta = in_y_end - in_y_start;
         set_row_step  = STEP_PLUS;
      end else if (in_y_end < in_y_start) begin
         set_row_delta = in_y_start - in_y_end;
         set_row_step  = STEP_MINUS;
      end else begin
         set_row_delta = '0;
         set_row_step  = STEP_ZERO;
      end
      set_major = (set_col_delta > set_row_delta) ? set_col_delta : set_row_delta;
   end

   // one point: grow errors, step an axis when its error passes the major length
   always_comb begin
      major_ext  = {1'b0, major_length_ff};
      col_sum    = col_error_ff + {1'b0, col_delta_ff};
      row_sum    = row_error_ff + {1'b0, row_delta_ff};
      col_hit    = col_sum > major_ext;
      row_hit    = row_sum > major_ext;
      points_dec = points_left_ff - ERR_BITS'(1);
      step_last  = (points_dec == '0);

      unique case (col_step_ff)
         STEP_PLUS:  col_moved = cur_col_ff + COORD_BITS'(1);
         STEP_MINUS: col_moved = cur_col_ff - COORD_BITS'(1);
         default:    col_moved = cur_col_ff;
      endcase
      unique case (row_step_ff)
         STEP_PLUS:  row_moved = cur_row_ff + COORD_BITS'(1);
         STEP_MINUS: row_moved = cur_row_ff - COORD_BITS'(1);
         default:    row_moved = cur_row_ff;
      endcase

      col_next = col_hit ? col_moved : cur_col_ff;
      row_next = row_hit ? row_moved : cur_row_ff;
   end

   // a step on an active line needs the result register; anything else advances without it
   assign emits   = (in_operation == OP_STEP) && line_active_ff;
   assign advance = in_valid && (!emits || out_free);

   always_comb begin
      line_active_in  = line_active_ff;
      cur_col_in      = cur_col_ff;
      cur_row_in      = cur_row_ff;
      col_error_in    = col_error_ff;
      row_error_in    = row_error_ff;
      col_delta_in    = col_delta_ff;
      row_delta_in    = row_delta_ff;
      col_step_in     = col_step_ff;
      row_step_in     = row_step_ff;
      major_length_in = major_length_ff;
      points_left_in  = points_left_ff;
      if (advance) begin
         if (in_operation == OP_START) begin
            line_active_in  = 1'b1;
            cur_col_in      = in_x_start;
            cur_row_in      = in_y_start;
            col_error_in    = '0;
            row_error_in    = '0;
            col_delta_in    = set_col_delta;
            row_delta_in    = set_row_delta;
            col_step_in     = set_col_step;
            row_step_in     = set_row_step;
            major_length_in = set_major;
            points_left_in  = {1'b0, set_major} + ERR_BITS'(1);
         end else if (line_active_ff) begin
            cur_col_in     = col_next;
            cur_row_in     = row_next;
            col_error_in   = col_hit ? (col_sum - major_ext) : col_sum;
            row_error_in   = row_hit ? (row_sum - major_ext) : row_sum;
            points_left_in = points_dec;
            line_active_in = !step_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff  <= 1'b0;
         cur_col_ff      <= '0;
         cur_row_ff      <= '0;
         col_error_ff    <= '0;
         row_error_ff    <= '0;
         col_delta_ff    <= '0;
         row_delta_ff    <= '0;
         col_step_ff     <= STEP_ZERO;
         row_step_ff     <= STEP_ZERO;
         major_length_ff <= '0;
         points_left_ff  <= '0;
      end else begin
         line_active_ff  <= line_active_in;
         cur_col_ff      <= cur_col_in;
         cur_row_ff      <= cur_row_in;
         col_error_ff    <= col_error_in;
         row_error_ff    <= row_error_in;
         col_delta_ff    <= col_delta_in;
         row_delta_ff    <= row_delta_in;
         col_step_ff     <= col_step_in;
         row_step_ff     <= row_step_in;
         major_length_ff <= major_length_in;
         points_left_ff  <= points_left_in;
      end
   end

   assign ctl.advance = advance;
   assign ctl.emit    = advance && emits;
   assign ctl.last    = step_last;
   assign ctl.active  = line_active_ff;
   assign point_x     = col_next;
   assign point_y     = row_next;

endmodule

`default_nettype wire

### hw/rtl/lpg_rsp_stage.sv
`default_nettype none

module lpg_rsp_stage #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   lpg_rsp_if.source                           rsp_chan,
   input  wire logic                           load,
   input  wire logic [COORD_BITS-1:0]          point_x,
   input  wire logic [COORD_BITS-1:0]          point_y,
   input  wire logic [lpg_pkg::COLOR_BITS-1:0] pixel_color,
   input  wire logic                           last_point,
   output logic                                out_free
);
   import lpg_pkg::*;

   logic                  valid_ff, valid_in;
   logic [COORD_BITS-1:0] point_x_ff, point_y_ff;
   logic [COLOR_BITS-1:0] pixel_color_ff;
   logic                  last_point_ff;

   // free when empty or the held point is taken this cycle
   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         point_x_ff     <= point_x;
         point_y_ff     <= point_y;
         pixel_color_ff <= pixel_color;
         last_point_ff  <= last_point;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.point_x     = point_x_ff;
   assign rsp_chan.point_y     = point_y_ff;
   assign rsp_chan.pixel_color = pixel_color_ff;
   assign rsp_chan.last_point  = last_point_ff;

endmodule

`default_nettype wire

### hw/rtl/line_point_generator_unit.sv
// Line point generator: start requests load endpoints, step requests emit points.
// A step request is captured in the input register; its point is computed
// combinationally and written to the result register once that has room.
// Throughput: one request per cycle, set by the combinational error/coordinate update;
// a step request waits in the input register while a held point is not taken.
// Reset: synchronous, active high; clears valids, line state and draw color.
`default_nettype none

`include "line_point_generator_unit_defines.svh"

module line_point_generator_unit #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   lpg_req_if.sink   req_chan,
   lpg_rsp_if.source rsp_chan,
   lpg_csr_if.sink   csr_chan
);
   import lpg_pkg::*;

   logic [COLOR_BITS-1:0] draw_color_ff, draw_color_in;
   lpg_ctl_type           ctl;
   logic                  in_valid, in_operation, out_free;
   logic [COORD_BITS-1:0] in_x_start, in_y_start, in_x_end, in_y_end;
   logic [COORD_BITS-1:0] point_x, point_y;

   // color register, always writable
   assign csr_chan.ready = 1'b1;
   assign draw_color_in  = csr_chan.valid ? csr_chan.draw_color : draw_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_color_ff <= '0;
      end else begin
         draw_color_ff <= draw_color_in;
      end
   end

   lpg_req_stage #(.COORD_BITS(COORD_BITS)) u_req_stage (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .advance      (ctl.advance),
      .in_valid     (in_valid),
      .in_operation (in_operation),
      .in_x_start   (in_x_start),
      .in_y_start   (in_y_start),
      .in_x_end     (in_x_end),
      .in_y_end     (in_y_end)
   );

   lpg_line_core #(.COORD_BITS(COORD_BITS)) u_line_core (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (in_valid),
      .in_operation (in_operation),
      .in_x_start   (in_x_start),
      .in_y_start   (in_y_start),
      .in_x_end     (in_x_end),
      .in_y_end     (in_y_end),
      .out_free     (out_free),
      .ctl          (ctl),
      .point_x      (point_x),
      .point_y      (point_y)
   );

   lpg_rsp_stage #(.COORD_BITS(COORD_BITS)) u_rsp_stage (
      .clock       (clock),
      .reset       (reset),
      .rsp_chan    (rsp_chan),
      .load        (ctl.emit),
      .point_x     (point_x),
      .point_y     (point_y),
      .pixel_color (draw_color_ff),
      .last_point  (ctl.last),
      .out_free    (out_free)
   );

   // a point is only written when the result register has room
   `LPG_ASSERT_NOW(a_emit_needs_room, clock, reset, ctl.emit, out_free)
   // points come only from an active line
   `LPG_ASSERT_NOW(a_emit_needs_line, clock, reset, ctl.emit, ctl.active)
   // the last point closes the line
   `LPG_ASSERT_NEXT(a_last_ends_line, clock, reset, ctl.emit && ctl.last, !ctl.active)
   // a stalled input means a request is held
   `LPG_ASSERT_NOW(a_stall_has_request, clock, reset, !req_chan.ready, in_valid)

endmodule

`default_nettype wire
